/* rtl/core/wsdt_pkg.sv */
// wsdt_pkg: shared types and constants of the wildcard signature dispatch table
// field widths, operation and status codes, controller/datapath command and status structs
// no dependencies
package wsdt_pkg;

  localparam int FUNC_ID_W   = 8;
  localparam int METHOD_ID_W = 16;
  localparam int ARITY_W     = 3;
  localparam int TYPE_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int TOTAL_W     = 32;
  localparam int TYPE_FIELDS = 4;

  localparam logic OP_DEFINE   = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [TYPE_W-1:0] TYPE_ANY = 2'd0;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_AMBIG   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd5;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic define;
    logic scan;
    logic report;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/core/wsdt_if.sv */
// wsdt_req_if / wsdt_rsp_if: valid/ready channels of the dispatch table
// depends on wsdt_pkg for field widths
interface wsdt_req_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [wsdt_pkg::FUNC_ID_W-1:0]      func_id;
  logic [wsdt_pkg::METHOD_ID_W-1:0]    method_code;
  logic [wsdt_pkg::ARITY_W-1:0]        arity;
  logic [wsdt_pkg::TYPE_W-1:0]         type_a;
  logic [wsdt_pkg::TYPE_W-1:0]         type_b;
  logic [wsdt_pkg::TYPE_W-1:0]         type_c;
  logic [wsdt_pkg::TYPE_W-1:0]         type_d;

  modport source (output valid, op, func_id, method_code, arity, type_a, type_b, type_c, type_d,
                  input ready);
  modport sink (input valid, op, func_id, method_code, arity, type_a, type_b, type_c, type_d,
                output ready);
endinterface

interface wsdt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [wsdt_pkg::STATUS_W-1:0]       status;
  logic [wsdt_pkg::METHOD_ID_W-1:0]    chosen_method;
  logic [wsdt_pkg::TOTAL_W-1:0]        dispatch_total;

  modport source (output valid, status, chosen_method, dispatch_total, input ready);
  modport sink (input valid, status, chosen_method, dispatch_total, output ready);
endinterface

/* rtl/core/wsdt_ram.sv */
// wsdt_ram: generic single-port ram with registered read
// no dependencies
module wsdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/wsdt_ctrl.sv */
// wsdt_ctrl: sequencing state machine of the dispatch table
// depends on wsdt_pkg for the command and status structs
module wsdt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_op,
  output logic                 req_ready,
  input  wsdt_pkg::dp_status_t st,
  output wsdt_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DEFINE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req_op == wsdt_pkg::OP_DEFINE) ? S_DEFINE : S_SCAN;
        end
      end
      S_DEFINE: begin
        state_next = S_REPORT;
      end
      S_SCAN: begin
        if (st.scan_done) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready   = (state == S_IDLE);
  assign cmd.capture = (state == S_IDLE) && req_valid;
  assign cmd.define  = (state == S_DEFINE);
  assign cmd.scan    = (state == S_SCAN);
  assign cmd.report  = (state == S_REPORT) && st.out_free;

endmodule

/* rtl/core/wsdt_datapath.sv */
// wsdt_datapath: item registers, signature memory, scan evaluation and output register
// depends on wsdt_pkg and wsdt_ram
module wsdt_datapath #(
  parameter int MAX_METHODS    = 64,
  parameter int MAX_ARITY      = 4,
  parameter int FUNC_ID_BITS   = 8,
  parameter int METHOD_ID_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wsdt_pkg::dp_cmd_t                    cmd,
  output wsdt_pkg::dp_status_t                 st,
  input  logic                                 req_op,
  input  logic [wsdt_pkg::FUNC_ID_W-1:0]       req_func_id,
  input  logic [wsdt_pkg::METHOD_ID_W-1:0]     req_method_code,
  input  logic [wsdt_pkg::ARITY_W-1:0]         req_arity,
  input  logic [wsdt_pkg::TYPE_W-1:0]          req_type_a,
  input  logic [wsdt_pkg::TYPE_W-1:0]          req_type_b,
  input  logic [wsdt_pkg::TYPE_W-1:0]          req_type_c,
  input  logic [wsdt_pkg::TYPE_W-1:0]          req_type_d,
  input  logic                                 rsp_ready,
  output logic                                 rsp_valid,
  output logic [wsdt_pkg::STATUS_W-1:0]        rsp_status,
  output logic [wsdt_pkg::METHOD_ID_W-1:0]     rsp_chosen_method,
  output logic [wsdt_pkg::TOTAL_W-1:0]         rsp_dispatch_total
);

  localparam int FID_W   = (FUNC_ID_BITS < wsdt_pkg::FUNC_ID_W) ? FUNC_ID_BITS
                                                                 : wsdt_pkg::FUNC_ID_W;
  localparam int MID_W   = (METHOD_ID_BITS < wsdt_pkg::METHOD_ID_W) ? METHOD_ID_BITS
                                                                     : wsdt_pkg::METHOD_ID_W;
  localparam int SLOTS   = (MAX_ARITY < wsdt_pkg::TYPE_FIELDS) ? MAX_ARITY
                                                              : wsdt_pkg::TYPE_FIELDS;
  localparam int TW      = wsdt_pkg::TYPE_W;
  localparam int AW      = wsdt_pkg::ARITY_W;
  localparam int TYPES_W = TW * SLOTS;
  localparam int ENTRY_W = FID_W + MID_W + AW + TYPES_W;
  localparam int ADDR_W  = $clog2(MAX_METHODS);
  localparam int CNT_W   = $clog2(MAX_METHODS + 1);
  localparam int SCORE_W = $clog2(SLOTS + 1);

  // item registers
  logic                                 op_q;
  logic [FID_W-1:0]                     func_q;
  logic [MID_W-1:0]                     method_q;
  logic [AW-1:0]                        arity_q;
  logic [SLOTS-1:0][TW-1:0]             types_q;
  logic [wsdt_pkg::TYPE_FIELDS-1:0][TW-1:0] req_types;

  // table and scan state
  logic [CNT_W-1:0]                     used;
  logic [CNT_W-1:0]                     idx;
  logic                                 pend;
  logic                                 known;
  logic                                 have;
  logic                                 ambig;
  logic [SCORE_W-1:0]                   top_score;
  logic [MID_W-1:0]                     best_method;
  logic [wsdt_pkg::STATUS_W-1:0]        def_status;
  logic [wsdt_pkg::TOTAL_W-1:0]         counter;
  logic [wsdt_pkg::TOTAL_W-1:0]         counter_next;

  // memory port
  logic                                 ram_we;
  logic [ADDR_W-1:0]                    ram_addr;
  logic [ENTRY_W-1:0]                   ram_wdata;
  logic [ENTRY_W-1:0]                   ram_rdata;

  // entry read back
  logic [FID_W-1:0]                     e_func;
  logic [MID_W-1:0]                     e_method;
  logic [AW-1:0]                        e_arity;
  logic [SLOTS-1:0][TW-1:0]             e_types;
  logic [SCORE_W-1:0]                   e_score;
  logic                                 types_ok;
  logic                                 func_seen;
  logic                                 hit;
  logic                                 issue;

  logic                                 arity_bad;
  logic                                 table_full;
  logic [SLOTS-1:0][TW-1:0]             def_types;

  logic [wsdt_pkg::STATUS_W-1:0]        res_status;
  logic [wsdt_pkg::METHOD_ID_W-1:0]     res_method;

  assign req_types = {req_type_d, req_type_c, req_type_b, req_type_a};

  // define checks; slots past the arity are stored as wildcard
  assign arity_bad  = (arity_q == '0) || (int'(arity_q) > MAX_ARITY);
  assign table_full = (used == CNT_W'(MAX_METHODS));

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      def_types[s] = (s < int'(arity_q)) ? types_q[s] : wsdt_pkg::TYPE_ANY;
    end
  end

  assign ram_wdata = {func_q, method_q, arity_q, def_types};
  assign ram_we    = cmd.define && !arity_bad && !table_full;
  assign ram_addr  = cmd.define ? used[ADDR_W-1:0] : idx[ADDR_W-1:0];
  assign issue     = cmd.scan && (idx != used) && !ambig;

  wsdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_METHODS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign e_types  = ram_rdata[TYPES_W-1:0];
  assign e_arity  = ram_rdata[TYPES_W +: AW];
  assign e_method = ram_rdata[TYPES_W + AW +: MID_W];
  assign e_func   = ram_rdata[TYPES_W + AW + MID_W +: FID_W];

  // slot match and specificity (count of non-wildcard slots, ordered like 10 per slot)
  always_comb begin
    types_ok = 1'b1;
    e_score  = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (e_types[s] != wsdt_pkg::TYPE_ANY) begin
        e_score = e_score + 1'b1;
        if (e_types[s] != types_q[s]) begin
          types_ok = 1'b0;
        end
      end
    end
  end

  assign func_seen = pend && !ambig && (e_func == func_q);
  assign hit       = func_seen && (e_arity == arity_q) && types_ok;

  // result of the current item
  always_comb begin
    res_method = '0;
    if (op_q == wsdt_pkg::OP_DEFINE) begin
      res_status = def_status;
    end else if (!known) begin
      res_status = wsdt_pkg::ST_MISSING;
    end else if (ambig) begin
      res_status = wsdt_pkg::ST_AMBIG;
    end else if (!have) begin
      res_status = wsdt_pkg::ST_NOMATCH;
    end else begin
      res_status = wsdt_pkg::ST_OK;
      res_method = wsdt_pkg::METHOD_ID_W'(best_method);
    end
  end

  // a dispatch of a known function is counted, whatever its outcome
  assign counter_next = ((op_q == wsdt_pkg::OP_DISPATCH) && known) ? counter + 1'b1 : counter;

  assign st.scan_done = ambig || ((idx == used) && !pend);
  assign st.out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      counter   <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        op_q     <= req_op;
        func_q   <= req_func_id[FID_W-1:0];
        method_q <= req_method_code[MID_W-1:0];
        arity_q  <= req_arity;
        types_q  <= req_types[SLOTS-1:0];
        idx      <= '0;
        pend     <= 1'b0;
        known    <= 1'b0;
        have     <= 1'b0;
        ambig    <= 1'b0;
      end else if (cmd.scan) begin
        pend <= issue;
        if (issue) begin
          idx <= idx + 1'b1;
        end
        if (func_seen) begin
          known <= 1'b1;
        end
        if (hit) begin
          if (!have || (e_score > top_score)) begin
            have        <= 1'b1;
            top_score   <= e_score;
            best_method <= e_method;
          end else if (e_score == top_score) begin
            ambig <= 1'b1;
          end
        end
      end

      if (cmd.define) begin
        if (arity_bad) begin
          def_status <= wsdt_pkg::ST_EMPTY;
        end else if (table_full) begin
          def_status <= wsdt_pkg::ST_FULL;
        end else begin
          def_status <= wsdt_pkg::ST_OK;
          used       <= used + 1'b1;
        end
      end

      if (cmd.report) begin
        rsp_valid          <= 1'b1;
        rsp_status         <= res_status;
        rsp_chosen_method  <= res_method;
        rsp_dispatch_total <= counter_next;
        counter            <= counter_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/wildcard_signature_dispatch_table.sv */
// wildcard_signature_dispatch_table: top level joining controller and datapath
// depends on wsdt_pkg, wsdt_if, wsdt_ctrl, wsdt_datapath
//
// Usage: items arrive on req (valid/ready). op selects define or dispatch.
// A define appends a signature unless its arity is bad or the table is full; a
// dispatch walks all stored entries in insertion order through one memory read
// port and is counted if its function is known. Each item produces exactly one
// transaction on rsp. Timing: a define passes through the define and report
// states before rsp.valid. A dispatch reads one entry per cycle while scanning;
// an ambiguous match ends the walk early.
// Throughput: one item at a time; req.ready is high only while no item is in
// work, so a new item is taken in the cycle after the last result is loaded.
// The next item is accepted while a finished result waits in the output
// register, so a stalled receiver holds back at most one further item.
// Reset: the entry count and the dispatch counter clear at once; the memory
// needs no clearing pass since only written entries are read.
// Stall: rsp holds status, chosen_method and dispatch_total until rsp.ready.
module wildcard_signature_dispatch_table #(
  parameter int MAX_METHODS    = 64,
  parameter int MAX_ARITY      = 4,
  parameter int FUNC_ID_BITS   = 8,
  parameter int METHOD_ID_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  wsdt_req_if.sink  req,
  wsdt_rsp_if.source rsp
);

  wsdt_pkg::dp_cmd_t    cmd;
  wsdt_pkg::dp_status_t st;

  wsdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  wsdt_datapath #(
    .MAX_METHODS    (MAX_METHODS),
    .MAX_ARITY      (MAX_ARITY),
    .FUNC_ID_BITS   (FUNC_ID_BITS),
    .METHOD_ID_BITS (METHOD_ID_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .st                 (st),
    .req_op             (req.op),
    .req_func_id        (req.func_id),
    .req_method_code    (req.method_code),
    .req_arity          (req.arity),
    .req_type_a         (req.type_a),
    .req_type_b         (req.type_b),
    .req_type_c         (req.type_c),
    .req_type_d         (req.type_d),
    .rsp_ready          (rsp.ready),
    .rsp_valid          (rsp.valid),
    .rsp_status         (rsp.status),
    .rsp_chosen_method  (rsp.chosen_method),
    .rsp_dispatch_total (rsp.dispatch_total)
  );

endmodule

/* rtl/core/wsdt_checker.sv */
// wsdt_checker: port-level assertions of the dispatch table, bound to the top level
// depends on wsdt_pkg and wildcard_signature_dispatch_table
module wsdt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic [wsdt_pkg::STATUS_W-1:0]       status,
  input logic [wsdt_pkg::METHOD_ID_W-1:0]    chosen_method
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(chosen_method))
    else $error("result changed while stalled");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input accepted while an item is in work");

  // only a successful dispatch carries a method id
  a_method_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != wsdt_pkg::ST_OK) |-> chosen_method == '0)
    else $error("method id reported on a failed item");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind wildcard_signature_dispatch_table wsdt_checker u_wsdt_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .chosen_method (rsp.chosen_method)
);
